// ===== rtl/mstg_pkg.sv =====
// Shared types and constants for the multichannel sine table generator.
// Used by the top level and the sample packer; no dependencies.
package mstg_pkg;

    // Default sizes of the synthesis core
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int PHASE_BITS_DEF  = 32;
    localparam int SINE_BITS_DEF   = 16;

    // Fixed field widths
    localparam int NUM_CH      = 4;   // channels with their own step register
    localparam int CH_W        = 2;
    localparam int STEP_W      = 32;
    localparam int CNT_W       = 3;
    localparam int AMP_W       = 31;
    localparam int SAMPLE_W    = 32;
    localparam int BCNT_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Sample formats
    typedef enum logic [2:0] {
        FMT_S16_LE    = 3'd0,
        FMT_S16_BE    = 3'd1,
        FMT_S24_3LE   = 3'd2,
        FMT_S24_3BE   = 3'd3,
        FMT_S24_4LE   = 3'd4,
        FMT_S24_4BE   = 3'd5,
        FMT_S32_LE    = 3'd6,
        FMT_S32_BE    = 3'd7
    } t_fmt;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_A    = 3'd0,
        REG_STEP_B    = 3'd1,
        REG_STEP_C    = 3'd2,
        REG_STEP_D    = 3'd3,
        REG_CH_COUNT  = 3'd4,
        REG_FORMAT    = 3'd5,
        REG_PAD_MODE  = 3'd6,
        REG_AMPLITUDE = 3'd7
    } t_cfg_reg;

    // Packing controls handed to the packer
    typedef struct packed {
        t_fmt fmt;
        logic pad_low;   // pad byte goes first
        logic pad_sign;  // pad byte copies sample bit 23
    } t_pack_ctl;

endpackage

// ===== rtl/multichannel_sine_table_generator_unit.sv =====
// Multichannel DDS sine generator: phase accumulators, sine table, gain and byte packing.
// Depends on mstg_pkg, mstg_sine_rom and mstg_packer.
//
// Each accepted input item with frame_tick set produces one output item per active
// channel (channel_count, 0 taken as 1, above 4 taken as 4), channels in order, tlast
// on the final one; an item with frame_tick clear is taken and produces nothing.
// Channels are issued one per cycle while the output is not stalled, through a single
// accumulator update and table read, and the next tick is taken in the cycle its last
// channel issues. The tick opens the sequencer; each issued channel then passes the
// index, table read, gain multiply and pack registers. Backpressure on the output
// stalls the whole pipeline. The user must write configuration only while the block
// is idle; the block itself does not enforce it.
module multichannel_sine_table_generator_unit #(
    parameter int TABLE_DEPTH = mstg_pkg::TABLE_DEPTH_DEF,
    parameter int PHASE_BITS  = mstg_pkg::PHASE_BITS_DEF,
    parameter int SINE_BITS   = mstg_pkg::SINE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items: [0] frame_tick
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [mstg_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // output items: [1:0] channel_index, [33:2] packed_bytes, [36:34] byte_count
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [mstg_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                               o_m_axis_tlast,   // last_of_frame
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [mstg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mstg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int SCALE_W = PHASE_BITS + IDX_W;
    localparam int SUM_W   = (PHASE_BITS > mstg_pkg::STEP_W) ? PHASE_BITS : mstg_pkg::STEP_W;
    localparam int PROD_W  = SINE_BITS + mstg_pkg::AMP_W + 1;

    // Configuration registers
    logic [mstg_pkg::NUM_CH-1:0][mstg_pkg::STEP_W-1:0] r_step;
    logic [mstg_pkg::CNT_W-1:0]                        r_cnt;
    mstg_pkg::t_fmt                                    r_fmt;
    logic [1:0]                                        r_pad;
    logic [mstg_pkg::AMP_W-1:0]                        r_amp;

    // Phase accumulators
    logic [mstg_pkg::NUM_CH-1:0][PHASE_BITS-1:0]       r_acc;

    // Channel sequencer
    logic                        r_busy;
    logic [mstg_pkg::CH_W-1:0]   r_ch;
    logic [mstg_pkg::CH_W-1:0]   r_last_ch;
    logic [mstg_pkg::CH_W-1:0]   w_last_eff;

    // Pipeline stages
    logic                        r_v1, r_v2, r_v3, r_ov;
    logic [mstg_pkg::CH_W-1:0]   r_ch1, r_ch2, r_ch3, r_och;
    logic                        r_last1, r_last2, r_last3, r_olast;
    logic [IDX_W-1:0]            r_idx1;
    logic [mstg_pkg::SAMPLE_W-1:0] r_sample;
    logic [31:0]                 r_obytes;
    logic [mstg_pkg::BCNT_W-1:0] r_ocnt;

    logic                        w_adv, w_issue, w_at_last, w_in_acc, w_start;
    logic [SUM_W-1:0]            w_sum;
    logic [PHASE_BITS-1:0]       w_new_acc;
    logic [SCALE_W-1:0]          w_scaled;
    logic [IDX_W-1:0]            w_idx;
    logic signed [SINE_BITS-1:0] w_rom_data;
    logic signed [mstg_pkg::AMP_W:0] w_amp_s;
    logic signed [PROD_W-1:0]    w_prod;
    mstg_pkg::t_pack_ctl         w_ctl;
    logic [31:0]                 w_bytes;
    logic [mstg_pkg::BCNT_W-1:0] w_bcnt;

    // Handshake and issue control; nothing is taken while in reset
    assign w_adv           = !r_ov || i_m_axis_tready;
    assign w_issue         = r_busy && w_adv;
    assign w_at_last       = (r_ch == r_last_ch);
    assign o_s_axis_tready = i_rst_n && (!r_busy || (w_adv && w_at_last));
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_start         = w_in_acc && i_s_axis_tdata[0];

    // Last active channel from the count register
    always_comb begin
        if (r_cnt == '0) begin
            w_last_eff = '0;
        end else if (r_cnt inside {[3'd1:3'd4]}) begin
            w_last_eff = mstg_pkg::CH_W'(r_cnt - 3'd1);
        end else begin
            w_last_eff = mstg_pkg::CH_W'(mstg_pkg::NUM_CH - 1);
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_cnt  <= 3'd2;
            r_fmt  <= mstg_pkg::FMT_S16_LE;
            r_pad  <= '0;
            r_amp  <= mstg_pkg::AMP_W'(32767);
        end else if (i_cfg_we) begin
            case (mstg_pkg::t_cfg_reg'(i_cfg_idx))
                mstg_pkg::REG_STEP_A,
                mstg_pkg::REG_STEP_B,
                mstg_pkg::REG_STEP_C,
                mstg_pkg::REG_STEP_D:
                    r_step[i_cfg_idx[mstg_pkg::CH_W-1:0]] <= i_cfg_data[mstg_pkg::STEP_W-1:0];
                mstg_pkg::REG_CH_COUNT:  r_cnt <= i_cfg_data[mstg_pkg::CNT_W-1:0];
                mstg_pkg::REG_FORMAT:    r_fmt <= mstg_pkg::t_fmt'(i_cfg_data[2:0]);
                mstg_pkg::REG_PAD_MODE:  r_pad <= i_cfg_data[1:0];
                mstg_pkg::REG_AMPLITUDE: r_amp <= i_cfg_data[mstg_pkg::AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // Channel sequencer: one channel issued per cycle while a frame is open and the output is not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_ch      <= '0;
            r_last_ch <= '0;
        end else if (w_start) begin
            r_busy    <= 1'b1;
            r_ch      <= '0;
            r_last_ch <= w_last_eff;
        end else if (w_issue) begin
            if (w_at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_ch <= r_ch + 1'b1;
            end
        end
    end

    // Phase advance and table index of the issued channel
    assign w_sum     = SUM_W'(r_acc[r_ch]) + SUM_W'(r_step[r_ch]);
    assign w_new_acc = w_sum[PHASE_BITS-1:0];
    assign w_scaled  = SCALE_W'(w_new_acc) * SCALE_W'(TABLE_DEPTH);
    assign w_idx     = w_scaled[PHASE_BITS +: IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_issue) begin
            r_acc[r_ch] <= w_new_acc;
        end
    end

    // Pipeline valids, moved together when the output can advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ch1    <= r_ch;
            r_last1  <= w_at_last;
            r_idx1   <= w_idx;
            r_ch2    <= r_ch1;
            r_last2  <= r_last1;
            r_ch3    <= r_ch2;
            r_last3  <= r_last2;
            r_sample <= w_prod[SINE_BITS-1 +: mstg_pkg::SAMPLE_W];
            r_och    <= r_ch3;
            r_olast  <= r_last3;
            r_obytes <= w_bytes;
            r_ocnt   <= w_bcnt;
        end
    end

    // Sine table lookup
    mstg_sine_rom #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SINE_BITS   (SINE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_addr (r_idx1),
        .o_data (w_rom_data)
    );

    // Gain: exact product, arithmetic shift by SINE_BITS-1, low 32 bits kept
    assign w_amp_s = $signed({1'b0, r_amp});
    assign w_prod  = w_rom_data * w_amp_s;

    // Byte packing
    assign w_ctl.fmt      = r_fmt;
    assign w_ctl.pad_low  = r_pad[0];
    assign w_ctl.pad_sign = r_pad[1];

    mstg_packer u_packer (
        .i_sample (r_sample),
        .i_ctl    (w_ctl),
        .o_bytes  (w_bytes),
        .o_count  (w_bcnt)
    );

    // Output register
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tdata  = {3'b000, r_ocnt, r_obytes, r_och};

    // A frame start opens the sequencer at channel 0
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_busy && r_ch == '0))
        else $error("frame start did not open the sequencer at channel 0");

    // Accumulators only move when a channel issues
    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_issue |=> $stable(r_acc))
        else $error("phase accumulator changed without an issued channel");

    // Issuing the last channel of a frame frees the input side
    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_at_last) |-> o_s_axis_tready)
        else $error("input not ready while the last channel of a frame issues");

endmodule

// ===== rtl/mstg_sine_rom.sv =====
// One-period sine table, signed Q1.(SINE_BITS-1), with registered read.
// Contents are computed at elaboration with a fixed-point Taylor series; no dependencies.
module mstg_sine_rom #(
    parameter int TABLE_DEPTH = 1024,
    parameter int SINE_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_addr,
    output logic signed [SINE_BITS-1:0]   o_data
);

    localparam longint unsigned   HalfPiQ30   = 64'd1686629713;
    localparam longint            Peak        = (64'sd1 <<< (SINE_BITS - 1)) - 64'sd1;
    localparam longint            RoundHalf   = 64'sd536870912;

    // sin(x), x in Q30 over [0, pi/2], result in Q30
    function automatic longint sin_q30(input longint unsigned x);
        longint           sum;
        longint unsigned  term;
        sum  = longint'(x);
        term = x;
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 6;
        sum  = sum - longint'(term);
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 20;
        sum  = sum + longint'(term);
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 42;
        sum  = sum - longint'(term);
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 72;
        sum  = sum + longint'(term);
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 110;
        sum  = sum - longint'(term);
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 156;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        return sum;
    endfunction

    logic signed [SINE_BITS-1:0] w_rom [TABLE_DEPTH];
    logic signed [SINE_BITS-1:0] r_data;

    // Table contents: quadrant folding, then round and clamp to the peak
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_rom
        localparam longint unsigned Quarter = longint'((4 * gi) / TABLE_DEPTH);
        localparam longint unsigned Rem     = longint'((4 * gi) % TABLE_DEPTH);
        localparam longint unsigned Num     = (Quarter % 2 == 1) ?
                                              (longint'(TABLE_DEPTH) - Rem) : Rem;
        localparam longint unsigned XQ30    = (Num * HalfPiQ30) / longint'(TABLE_DEPTH);
        localparam longint          Mag0    = (sin_q30(XQ30) * Peak + RoundHalf) >>> 30;
        localparam longint          Mag     = (Mag0 > Peak) ? Peak : Mag0;
        localparam longint          Val     = (Quarter >= 2) ? -Mag : Mag;
        assign w_rom[gi] = SINE_BITS'(Val);
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ===== rtl/mstg_packer.sv =====
// Byte packer: places a 32-bit sample into 2, 3 or 4 bytes per format and pad mode.
// Depends on mstg_pkg for the format codes and the control struct.
module mstg_packer (
    input  logic [mstg_pkg::SAMPLE_W-1:0] i_sample,
    input  mstg_pkg::t_pack_ctl           i_ctl,
    output logic [31:0]                   o_bytes,
    output logic [mstg_pkg::BCNT_W-1:0]   o_count
);

    logic [7:0] w_b0, w_b1, w_b2, w_b3, w_pad;

    assign w_b0  = i_sample[7:0];
    assign w_b1  = i_sample[15:8];
    assign w_b2  = i_sample[23:16];
    assign w_b3  = i_sample[31:24];
    assign w_pad = (i_ctl.pad_sign && i_sample[23]) ? 8'hff : 8'h00;

    // Byte order per format; unused bytes stay zero
    always_comb begin
        o_bytes = '0;
        o_count = 3'd4;
        case (i_ctl.fmt)
            mstg_pkg::FMT_S16_LE: begin
                o_count = 3'd2;
                o_bytes = {16'h0000, w_b1, w_b0};
            end
            mstg_pkg::FMT_S16_BE: begin
                o_count = 3'd2;
                o_bytes = {16'h0000, w_b0, w_b1};
            end
            mstg_pkg::FMT_S24_3LE: begin
                o_count = 3'd3;
                o_bytes = {8'h00, w_b2, w_b1, w_b0};
            end
            mstg_pkg::FMT_S24_3BE: begin
                o_count = 3'd3;
                o_bytes = {8'h00, w_b0, w_b1, w_b2};
            end
            mstg_pkg::FMT_S24_4LE: begin
                o_bytes = i_ctl.pad_low ? {w_b2, w_b1, w_b0, w_pad}
                                        : {w_pad, w_b2, w_b1, w_b0};
            end
            mstg_pkg::FMT_S24_4BE: begin
                o_bytes = i_ctl.pad_low ? {w_b0, w_b1, w_b2, w_pad}
                                        : {w_pad, w_b0, w_b1, w_b2};
            end
            mstg_pkg::FMT_S32_LE: begin
                o_bytes = {w_b3, w_b2, w_b1, w_b0};
            end
            default: begin
                o_bytes = {w_b0, w_b1, w_b2, w_b3};
            end
        endcase
    end

endmodule

// ===== dv/multichannel_sine_table_generator_unit_test.sv =====
// Self-checking bench for the multichannel sine table generator: frame ticks in,
// packed channel samples out, checked against an in-bench DDS predictor.
// Depends on mstg_pkg and multichannel_sine_table_generator_unit.
module multichannel_sine_table_generator_unit_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD = 200;
    localparam longint SINE_PEAK = (longint'(1) << (mstg_pkg::SINE_BITS_DEF - 1)) - 1;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // One expected output item
    typedef struct {
        bit [mstg_pkg::CH_W-1:0]   ch;
        bit [31:0]                 bytes;
        bit [mstg_pkg::BCNT_W-1:0] nbytes;
        bit                        last;
    } t_sample;

    logic                             i_clk;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [mstg_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;  // [0] frame_tick
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    // [1:0] channel_index, [33:2] packed_bytes, [36:34] byte_count
    logic [mstg_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                             o_m_axis_tlast;   // last_of_frame
    logic                             i_cfg_we = 1'b0;
    logic [mstg_pkg::CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [mstg_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    multichannel_sine_table_generator_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // Predictor state: register copies, accumulators and the sine table
    bit [mstg_pkg::STEP_W-1:0] step_reg [mstg_pkg::NUM_CH];
    bit [mstg_pkg::CNT_W-1:0]  lanes;
    mstg_pkg::t_fmt            fmt_reg;
    bit [1:0]                  pad_reg;
    bit [mstg_pkg::AMP_W-1:0]  gain;
    bit [31:0]                 phase_acc [mstg_pkg::NUM_CH];
    int                        sine_lut [mstg_pkg::TABLE_DEPTH_DEF];

    bit      tick_queue [$];
    t_sample samples_due [$];
    int      fails = 0;

    // Stream pacing controls
    bit       s_taken = 1'b0;
    bit       tx_steady = 1'b0;
    int       tx_gap = 0;
    int       tx_burst = 0;
    int       rx_mode = 0;
    int       hold_asked = 0;
    int       hold_seen = 0;
    int       hold_left = 0;
    bit [7:0] rx_pattern = 8'b1011_0110;

    // sin(x), x in Q30 over [0, pi/2], by a Taylor series to x^13
    function automatic longint sine_q30(longint unsigned x);
        longint          sum;
        longint unsigned term;
        sum = x;
        term = x;
        for (int k = 1; k <= 6; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        return sum;
    endfunction

    // Table word i, folded from the first quadrant and rounded to the peak
    function automatic int lut_word(int i);
        longint unsigned quarter, rest, num, x;
        longint          s, v;
        quarter = (4 * i) / mstg_pkg::TABLE_DEPTH_DEF;
        rest = (4 * i) % mstg_pkg::TABLE_DEPTH_DEF;
        num = quarter[0] ? mstg_pkg::TABLE_DEPTH_DEF - rest : rest;
        x = (num * HALF_PI_Q30) / mstg_pkg::TABLE_DEPTH_DEF;
        s = sine_q30(x);
        v = (s * SINE_PEAK + (longint'(1) << 29)) >>> 30;
        if (v > SINE_PEAK) v = SINE_PEAK;
        return (quarter >= 2) ? int'(-v) : int'(v);
    endfunction

    // Exact product, floor shift, low 32 bits kept
    function automatic bit [31:0] apply_gain(int w);
        longint prod;
        prod = longint'(w) * longint'({1'b0, gain});
        prod = prod >>> (mstg_pkg::SINE_BITS_DEF - 1);
        return prod[31:0];
    endfunction

    // Advance the active channels and queue one packed sample per channel
    function automatic void predict_frame();
        int              n;
        t_sample         e;
        longint unsigned ix;
        bit [31:0]       s;
        bit [7:0]        pb;
        bit [7:0]        by [4];
        n = (lanes == 0) ? 1 : ((lanes > mstg_pkg::NUM_CH) ? mstg_pkg::NUM_CH : lanes);
        for (int c = 0; c < n; c++) begin
            phase_acc[c] = phase_acc[c] + step_reg[c];
            ix = (64'(phase_acc[c]) * mstg_pkg::TABLE_DEPTH_DEF) >> mstg_pkg::PHASE_BITS_DEF;
            if (ix >= mstg_pkg::TABLE_DEPTH_DEF) ix = mstg_pkg::TABLE_DEPTH_DEF - 1;
            s = apply_gain(sine_lut[ix]);
            pb = (pad_reg[1] && s[23]) ? 8'hff : 8'h00;
            for (int j = 0; j < 4; j++) by[j] = 8'h00;
            case (fmt_reg)
                mstg_pkg::FMT_S16_LE: begin
                    e.nbytes = 3'd2; by[0] = s[7:0]; by[1] = s[15:8];
                end
                mstg_pkg::FMT_S16_BE: begin
                    e.nbytes = 3'd2; by[0] = s[15:8]; by[1] = s[7:0];
                end
                mstg_pkg::FMT_S24_3LE: begin
                    e.nbytes = 3'd3; by[0] = s[7:0]; by[1] = s[15:8]; by[2] = s[23:16];
                end
                mstg_pkg::FMT_S24_3BE: begin
                    e.nbytes = 3'd3; by[0] = s[23:16]; by[1] = s[15:8]; by[2] = s[7:0];
                end
                mstg_pkg::FMT_S24_4LE: begin
                    e.nbytes = 3'd4;
                    if (pad_reg[0]) begin
                        by[0] = pb; by[1] = s[7:0]; by[2] = s[15:8]; by[3] = s[23:16];
                    end else begin
                        by[0] = s[7:0]; by[1] = s[15:8]; by[2] = s[23:16]; by[3] = pb;
                    end
                end
                mstg_pkg::FMT_S24_4BE: begin
                    e.nbytes = 3'd4;
                    if (pad_reg[0]) begin
                        by[0] = pb; by[1] = s[23:16]; by[2] = s[15:8]; by[3] = s[7:0];
                    end else begin
                        by[0] = s[23:16]; by[1] = s[15:8]; by[2] = s[7:0]; by[3] = pb;
                    end
                end
                mstg_pkg::FMT_S32_LE: begin
                    e.nbytes = 3'd4; by[0] = s[7:0]; by[1] = s[15:8];
                    by[2] = s[23:16]; by[3] = s[31:24];
                end
                default: begin
                    e.nbytes = 3'd4; by[0] = s[31:24]; by[1] = s[23:16];
                    by[2] = s[15:8]; by[3] = s[7:0];
                end
            endcase
            e.bytes = {by[3], by[2], by[1], by[0]};
            e.ch = mstg_pkg::CH_W'(c);
            e.last = (c == n - 1);
            samples_due.push_back(e);
        end
    endfunction

    // Compare one output item with the oldest expected sample
    task automatic check_sample();
        t_sample want, got;
        got.ch = o_m_axis_tdata[1:0];
        got.bytes = o_m_axis_tdata[33:2];
        got.nbytes = o_m_axis_tdata[36:34];
        got.last = o_m_axis_tlast;
        if (samples_due.size() == 0) begin
            $error("sample with nothing due: tdata %h tlast %0b", o_m_axis_tdata, got.last);
            fails++;
        end else begin
            want = samples_due.pop_front();
            if (got.ch != want.ch) begin
                $error("channel_index: expected %0d, got %0d", want.ch, got.ch);
                fails++;
            end
            if (got.bytes != want.bytes) begin
                $error("packed_bytes: expected %h, got %h", want.bytes, got.bytes);
                fails++;
            end
            if (got.nbytes != want.nbytes) begin
                $error("byte_count: expected %0d, got %0d", want.nbytes, got.nbytes);
                fails++;
            end
            if (got.last != want.last) begin
                $error("last_of_frame: expected %0b, got %0b", want.last, got.last);
                fails++;
            end
        end
    endtask

    // Register write; the predictor copy follows at once since the block is idle
    task automatic write_reg(mstg_pkg::t_cfg_reg r, bit [31:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= r;
        i_cfg_data <= v;
        case (r)
            mstg_pkg::REG_STEP_A, mstg_pkg::REG_STEP_B,
            mstg_pkg::REG_STEP_C, mstg_pkg::REG_STEP_D: step_reg[int'(r)] = v;
            mstg_pkg::REG_CH_COUNT: lanes = v[mstg_pkg::CNT_W-1:0];
            mstg_pkg::REG_FORMAT:   fmt_reg = mstg_pkg::t_fmt'(v[2:0]);
            mstg_pkg::REG_PAD_MODE: pad_reg = v[1:0];
            default:                gain = v[mstg_pkg::AMP_W-1:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every item is taken and every sample has come out
    task automatic settle();
        do @(posedge i_clk);
        while (tick_queue.size() != 0 || i_s_axis_tvalid || samples_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_ticks(int n);
        for (int k = 0; k < n; k++) tick_queue.push_back($urandom_range(0, 99) < 85);
    endtask

    function automatic bit [31:0] pick_step();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 32'h00ff_ffff);
            1: return 32'hffff_ffff - $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic shuffle_settings();
        bit [31:0] a;
        write_reg(mstg_pkg::REG_STEP_A, pick_step());
        write_reg(mstg_pkg::REG_STEP_B, pick_step());
        write_reg(mstg_pkg::REG_STEP_C, pick_step());
        write_reg(mstg_pkg::REG_STEP_D, pick_step());
        write_reg(mstg_pkg::REG_CH_COUNT, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
                                                                       : $urandom_range(1, 4));
        write_reg(mstg_pkg::REG_FORMAT, $urandom_range(0, 7));
        write_reg(mstg_pkg::REG_PAD_MODE, $urandom_range(0, 3));
        case ($urandom_range(0, 4))
            0: a = 0;
            1: a = 32'h7fff_ffff;
            2: a = 32767;
            default: a = $urandom_range(0, 32'h7fff_ffff);
        endcase
        write_reg(mstg_pkg::REG_AMPLITUDE, a);
        rx_mode = $urandom_range(0, 3);
        tx_steady = ($urandom_range(0, 3) == 0);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Input driver: bursts of items with random gaps, no gaps in steady mode
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || s_taken) begin
            if (tx_gap > 0 && !tx_steady) begin
                tx_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
                i_s_axis_tdata <= {{(mstg_pkg::IN_TDATA_W-1){1'b0}}, tick_queue.pop_front()};
                i_s_axis_tvalid <= 1'b1;
                if (tx_burst > 0) begin
                    tx_burst--;
                end else begin
                    tx_burst = $urandom_range(0, 9);
                    tx_gap = $urandom_range(1, 8);
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output ready: long hold on request, otherwise the current stall pattern
    always @(negedge i_clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: begin
                    i_m_axis_tready <= rx_pattern[0];
                    rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                end
                default: i_m_axis_tready <= $urandom_range(0, 1);
            endcase
        end
    end

    // Monitor: check outputs, predict for each accepted tick
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_taken = 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) check_sample();
            s_taken = i_s_axis_tvalid && o_s_axis_tready;
            if (s_taken && i_s_axis_tdata[0]) predict_frame();
        end
    end

    // Run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    // Stimulus
    initial begin
        for (int c = 0; c < mstg_pkg::NUM_CH; c++) begin
            step_reg[c] = 0;
            phase_acc[c] = 0;
        end
        lanes = 2;
        fmt_reg = mstg_pkg::FMT_S16_LE;
        pad_reg = 0;
        gain = 32767;
        for (int i = 0; i < mstg_pkg::TABLE_DEPTH_DEF; i++) sine_lut[i] = lut_word(i);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero steps, idle ticks in between
        tick_queue = '{1, 0, 1};
        settle();

        // Quarter, max, one-entry and half-period steps at full gain
        write_reg(mstg_pkg::REG_STEP_A, 32'h4000_0000);
        write_reg(mstg_pkg::REG_STEP_B, 32'hffff_ffff);
        write_reg(mstg_pkg::REG_STEP_C, 32'h0040_0000);
        write_reg(mstg_pkg::REG_STEP_D, 32'h8000_0000);
        write_reg(mstg_pkg::REG_CH_COUNT, mstg_pkg::NUM_CH);
        write_reg(mstg_pkg::REG_AMPLITUDE, 32'h7fff_ffff);
        rx_mode = 1;
        tick_queue = '{1, 1, 1, 1};
        settle();

        // Each format from S16_BE to S32_BE once
        for (int f = int'(mstg_pkg::FMT_S16_BE); f <= int'(mstg_pkg::FMT_S32_BE); f++) begin
            write_reg(mstg_pkg::REG_FORMAT, f);
            write_reg(mstg_pkg::REG_PAD_MODE, f % 4);
            tick_queue.push_back(1'b1);
            settle();
        end

        // 24-in-32 pad byte placement and fill
        for (int p = 0; p < 4; p++) begin
            write_reg(mstg_pkg::REG_FORMAT,
                      (p % 2 == 0) ? mstg_pkg::FMT_S24_4LE : mstg_pkg::FMT_S24_4BE);
            write_reg(mstg_pkg::REG_PAD_MODE, p);
            tick_queue.push_back(1'b1);
            settle();
        end

        // Out-of-range channel counts, a single channel, zero gain
        write_reg(mstg_pkg::REG_CH_COUNT, 0);
        tick_queue.push_back(1'b1);
        settle();
        write_reg(mstg_pkg::REG_CH_COUNT, 7);
        tick_queue.push_back(1'b1);
        settle();
        write_reg(mstg_pkg::REG_CH_COUNT, 5);
        write_reg(mstg_pkg::REG_AMPLITUDE, 0);
        tick_queue.push_back(1'b1);
        settle();
        write_reg(mstg_pkg::REG_CH_COUNT, 1);
        write_reg(mstg_pkg::REG_AMPLITUDE, 32767);
        tick_queue = '{1, 1};
        settle();

        // Random settings and tick streams
        for (int ph = 0; ph < 8; ph++) begin
            shuffle_settings();
            if (ph == 3) begin
                // Hold the output off while the sender keeps offering ticks
                write_reg(mstg_pkg::REG_CH_COUNT, mstg_pkg::NUM_CH);
                tx_steady = 1'b1;
                rx_mode = 0;
                hold_asked++;
                for (int k = 0; k < 30; k++) tick_queue.push_back(1'b1);
            end else begin
                queue_ticks(10);
            end
            settle();
        end

        if (fails == 0 && samples_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
